[design/mtk_pkg.sv]
package mtk_pkg;

    // event codes of a result beat
    localparam logic [2:0] EV_PREVIEW = 3'd0;
    localparam logic [2:0] EV_COMMIT  = 3'd1;
    localparam logic [2:0] EV_DROPPED = 3'd2;
    localparam logic [2:0] EV_ERASE   = 3'd3;
    localparam logic [2:0] EV_SEND    = 3'd4;

    // raw key bytes
    localparam logic [7:0] KEY_BS    = 8'd8;
    localparam logic [7:0] KEY_ENTER = 8'd13;
    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_NINE  = 8'h39;
    localparam logic [7:0] KEY_STAR  = 8'h2A;
    localparam logic [7:0] KEY_HASH  = 8'h23;

    // key numbers of star and hash
    localparam logic [3:0] KNUM_STAR = 4'd10;
    localparam logic [3:0] KNUM_HASH = 4'd11;

    localparam int MESSAGE_CAPACITY = 256;
    localparam int TIMEOUT_RESET    = 8;

    // result queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] key_index;
        logic [3:0] position;
        logic [8:0] message_length;
        logic       last;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [3:0] num;
    } t_key_num;

    // decode a raw byte into a key number
    function automatic t_key_num key_number(input logic [7:0] code);
        t_key_num k;
        k.hit = 1'b0;
        k.num = 4'd0;
        if (code >= KEY_ZERO && code <= KEY_NINE) begin
            k.hit = 1'b1;
            k.num = code[3:0];
        end else if (code == KEY_STAR) begin
            k.hit = 1'b1;
            k.num = KNUM_STAR;
        end else if (code == KEY_HASH) begin
            k.hit = 1'b1;
            k.num = KNUM_HASH;
        end
        return k;
    endfunction

    // last letter position of each key
    function automatic logic [3:0] last_pos(input logic [3:0] kn);
        logic [3:0] p;
        unique case (kn)
            4'd0:                  p = 4'd1;
            4'd1:                  p = 4'd4;
            4'd7, 4'd9:            p = 4'd8;
            KNUM_STAR, KNUM_HASH:  p = 4'd0;
            default:               p = 4'd7;
        endcase
        return p;
    endfunction

endpackage

[design/mtk_in_if.sv]
interface mtk_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] key_code;

    modport source (output valid, output mode, output key_code, input ready);
    modport sink   (input valid, input mode, input key_code, output ready);
endinterface

[design/mtk_out_if.sv]
interface mtk_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [3:0] key_index;
    logic [3:0] position;
    logic [8:0] message_length;
    logic       last;

    modport source (
        output valid, output event_res, output key_index, output position,
        output message_length, output last, input ready
    );
    modport sink (
        input valid, input event_res, input key_index, input position,
        input message_length, input last, output ready
    );
endinterface

[design/multitap_keypad_text_entry_unit.sv]
// Multi-tap keypad text entry.
// i_key carries one beat per key press (mode 0) or timer tick (mode 1);
// o_res carries the result beats, none, one or two per input, with last set on
// the final beat of each input. i_cfg_we / i_cfg_data write the timeout
// in ticks.
// Result beats are written into the queue when the input beat is taken
// and are shown on o_res from its head. Throughput: one input beat per
// cycle while i_key.ready is high; the letter state is updated when the
// beat is taken, so any input may directly follow the previous one.
// Results go through a 4-entry queue. i_key.ready is high while at least
// two entries are free, so with the receiver taking a beat every cycle
// the input is never held off by single-result inputs; an input giving
// two results uses two output beats. When the receiver stalls the queue
// fills and i_key.ready drops; nothing is lost.
// Reset (synchronous, i_rst_n low) clears the pending letter, the idle
// count and the message length, empties the queue and sets the timeout
// to 8 ticks.
module multitap_keypad_text_entry_unit
    import mtk_pkg::*;
#(
    parameter int MSG_CAP = MESSAGE_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    mtk_in_if.sink     i_key,
    mtk_out_if.source  o_res
);

    localparam int CNT_W = $clog2(MSG_CAP + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // letter state
    logic [7:0]       r_timeout;
    logic             r_pending, n_pending;
    logic [3:0]       r_cur_key, n_cur_key;
    logic [3:0]       r_pos, n_pos;
    logic [7:0]       r_idle, n_idle;
    logic [CNT_W-1:0] r_held, n_held;

    // result queue
    t_result          r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_qcnt;

    logic     in_acc, out_acc;
    t_result  res0, res1;
    logic [1:0] nres;
    t_key_num kn;
    logic [7:0] idle_inc;

    assign in_acc  = i_key.valid && i_key.ready;
    assign out_acc = o_res.valid && o_res.ready;
    assign kn      = key_number(i_key.key_code);
    assign idle_inc = (r_idle == 8'hFF) ? r_idle : r_idle + 8'd1;

    // next letter state and result beats of this input
    always_comb begin
        logic [CNT_W-1:0] held_c;
        logic [2:0]       ev_c;
        n_pending = r_pending;
        n_cur_key = r_cur_key;
        n_pos     = r_pos;
        n_idle    = r_idle;
        n_held    = r_held;
        nres      = 2'd0;
        res0      = '0;
        res1      = '0;
        // commit outcome of the pending letter
        if (r_held < CNT_W'(MSG_CAP)) begin
            held_c = r_held + CNT_W'(1);
            ev_c   = EV_COMMIT;
        end else begin
            held_c = r_held;
            ev_c   = EV_DROPPED;
        end
        if (i_key.mode) begin
            if (r_pending) begin
                n_idle = idle_inc;
                if (idle_inc > r_timeout) begin
                    n_held    = held_c;
                    n_pending = 1'b0;
                    n_pos     = 4'd0;
                    n_idle    = 8'd0;
                    res0 = '{ev_c, r_cur_key, r_pos, 9'(held_c), 1'b1};
                    nres = 2'd1;
                end
            end
        end else if (kn.hit) begin
            n_idle = 8'd0;
            if (r_pending && kn.num == r_cur_key) begin
                n_pos = (r_pos >= last_pos(kn.num)) ? 4'd0 : r_pos + 4'd1;
                res0  = '{EV_PREVIEW, r_cur_key, n_pos, 9'(r_held), 1'b1};
                nres  = 2'd1;
            end else begin
                n_pending = 1'b1;
                n_cur_key = kn.num;
                n_pos     = 4'd0;
                if (r_pending) begin
                    n_held = held_c;
                    res0 = '{ev_c, r_cur_key, r_pos, 9'(held_c), 1'b0};
                    res1 = '{EV_PREVIEW, kn.num, 4'd0, 9'(held_c), 1'b1};
                    nres = 2'd2;
                end else begin
                    res0 = '{EV_PREVIEW, kn.num, 4'd0, 9'(r_held), 1'b1};
                    nres = 2'd1;
                end
            end
        end else if (i_key.key_code == KEY_BS || i_key.key_code == KEY_ENTER) begin
            n_pending = 1'b0;
            n_cur_key = 4'd0;
            n_pos     = 4'd0;
            n_idle    = 8'd0;
            if (i_key.key_code == KEY_BS) begin
                n_held = (r_held != '0) ? r_held - CNT_W'(1) : r_held;
                res0   = '{EV_ERASE, 4'd0, 4'd0, 9'(n_held), 1'b1};
            end else begin
                n_held = '0;
                res0   = '{EV_SEND, 4'd0, 4'd0, 9'd0, 1'b1};
            end
            nres = 2'd1;
        end
    end

    // configuration register and letter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 8'(TIMEOUT_RESET);
            r_pending <= 1'b0;
            r_cur_key <= 4'd0;
            r_pos     <= 4'd0;
            r_idle    <= 8'd0;
            r_held    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (in_acc) begin
                r_pending <= n_pending;
                r_cur_key <= n_cur_key;
                r_pos     <= n_pos;
                r_idle    <= n_idle;
                r_held    <= n_held;
            end
        end
    end

    // queue payload, up to two entries written per input beat
    always_ff @(posedge i_clk) begin
        if (in_acc && nres != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_acc && nres == 2'd2) begin
            r_queue[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_qcnt   <= '0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(nres);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_qcnt <= r_qcnt + (in_acc ? QCNT_W'(nres) : '0)
                             - (out_acc ? QCNT_W'(1) : '0);
        end
    end

    // room for the largest burst of one input
    assign i_key.ready = (r_qcnt <= QCNT_W'(QUEUE_DEPTH - 2));

    // head of queue drives the output channel
    assign o_res.valid          = (r_qcnt != '0);
    assign o_res.event_res      = r_queue[r_rd_ptr].event_res;
    assign o_res.key_index      = r_queue[r_rd_ptr].key_index;
    assign o_res.position       = r_queue[r_rd_ptr].position;
    assign o_res.message_length = r_queue[r_rd_ptr].message_length;
    assign o_res.last           = r_queue[r_rd_ptr].last;

endmodule

[test/multitap_keypad_text_entry_unit_test.sv]
module multitap_keypad_text_entry_unit_test;
    import mtk_pkg::*;

    localparam logic MODE_PRESS = 1'b0;
    localparam logic MODE_TICK  = 1'b1;
    localparam int   CYCLE_LIMIT = 300000;
    localparam int   SETTLE_CYCLES = 6;
    localparam int   IDLE_PERCENT = 36;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;

    mtk_in_if  key_if ();
    mtk_out_if res_if ();

    multitap_keypad_text_entry_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_key      (key_if),
        .o_res      (res_if)
    );

    // keypad state as the block should hold it
    logic [3:0] top_position [12] = '{4'd1, 4'd4, 4'd7, 4'd7, 4'd7, 4'd7,
                                     4'd7, 4'd8, 4'd7, 4'd8, 4'd0, 4'd0};
    logic [7:0] timeout_limit;
    logic       letter_pending;
    logic [3:0] pending_key;
    logic [3:0] pending_pos;
    logic [7:0] idle_count;
    int         held_letters;

    t_result predicted_events[$];
    int      mismatch_count;
    int      cycle_count;
    logic    no_idle;
    int      recent_key;

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multitap_keypad_text_entry_unit_test NOT OK");
            $finish;
        end
    end

    function automatic logic idle_roll();
        return !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    function automatic t_result letter_event(input logic [2:0] ev, input logic [3:0] kn,
                                             input logic [3:0] pos);
        t_result r;
        r.event_res = ev;
        r.key_index = kn;
        r.position = pos;
        r.message_length = 9'(held_letters);
        r.last = 1'b0;
        return r;
    endfunction

    // move the pending letter into the message, or drop it when full
    function automatic t_result commit_letter();
        logic [2:0] ev;
        t_result r;
        if (held_letters < MESSAGE_CAPACITY) begin
            held_letters++;
            ev = EV_COMMIT;
        end else begin
            ev = EV_DROPPED;
        end
        r = letter_event(ev, pending_key, pending_pos);
        letter_pending = 1'b0;
        pending_pos = 4'd0;
        idle_count = 8'd0;
        return r;
    endfunction

    // expected result beats of one accepted input beat
    task automatic predict_keypad(input logic m, input logic [7:0] code);
        t_result batch[$];
        logic hit;
        logic [3:0] kn;
        hit = 1'b0;
        kn = 4'd0;
        if (m == MODE_TICK) begin
            if (letter_pending) begin
                if (idle_count != 8'd255) idle_count++;
                if (idle_count > timeout_limit) batch.push_back(commit_letter());
            end
        end else begin
            if (code >= KEY_ZERO && code <= KEY_NINE) begin
                hit = 1'b1;
                kn = 4'(code - KEY_ZERO);
            end else if (code == KEY_STAR) begin
                hit = 1'b1;
                kn = KNUM_STAR;
            end else if (code == KEY_HASH) begin
                hit = 1'b1;
                kn = KNUM_HASH;
            end
            if (hit) begin
                if (letter_pending && kn == pending_key) begin
                    if (pending_pos >= top_position[kn]) pending_pos = 4'd0;
                    else pending_pos++;
                end else begin
                    if (letter_pending) batch.push_back(commit_letter());
                    letter_pending = 1'b1;
                    pending_key = kn;
                    pending_pos = 4'd0;
                end
                idle_count = 8'd0;
                batch.push_back(letter_event(EV_PREVIEW, pending_key, pending_pos));
            end else if (code == KEY_BS || code == KEY_ENTER) begin
                letter_pending = 1'b0;
                pending_key = 4'd0;
                pending_pos = 4'd0;
                idle_count = 8'd0;
                if (code == KEY_BS) begin
                    if (held_letters > 0) held_letters--;
                    batch.push_back(letter_event(EV_ERASE, 4'd0, 4'd0));
                end else begin
                    held_letters = 0;
                    batch.push_back(letter_event(EV_SEND, 4'd0, 4'd0));
                end
            end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) predicted_events.push_back(batch[i]);
    endtask

    task automatic check_field(input string name, input int exp, input int act);
        if (exp != act) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp, act);
            mismatch_count++;
        end
    endtask

    // result beat checker and receiver stalls
    always @(posedge clk) begin
        t_result exp;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (predicted_events.size() == 0) begin
                $display("%0t: unexpected beat event_res %0d key_index %0d", $time,
                         res_if.event_res, res_if.key_index);
                mismatch_count++;
            end else begin
                exp = predicted_events.pop_front();
                if ({res_if.event_res, res_if.key_index, res_if.position,
                     res_if.message_length, res_if.last} !== exp) begin
                    check_field("event_res", exp.event_res, res_if.event_res);
                    check_field("key_index", exp.key_index, res_if.key_index);
                    check_field("position", exp.position, res_if.position);
                    check_field("message_length", exp.message_length,
                                res_if.message_length);
                    check_field("last", exp.last, res_if.last);
                    if ($isunknown({res_if.event_res, res_if.key_index, res_if.position,
                                    res_if.message_length, res_if.last})) begin
                        $display("%0t: unknown bits in result beat", $time);
                        mismatch_count++;
                    end
                end
            end
        end
        res_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // send one input beat, idling at random first
    task automatic send_beat(input logic m, input logic [7:0] code);
        while (idle_roll()) begin
            key_if.valid <= 1'b0;
            @(posedge clk);
        end
        key_if.valid <= 1'b1;
        key_if.mode <= m;
        key_if.key_code <= code;
        @(posedge clk);
        while (!key_if.ready) @(posedge clk);
        predict_keypad(m, code);
    endtask

    function automatic logic [7:0] key_byte(input int kn);
        if (kn < 10) return KEY_ZERO + 8'(kn);
        if (kn == 10) return KEY_STAR;
        return KEY_HASH;
    endfunction

    task automatic press_key(input int kn);
        send_beat(MODE_PRESS, key_byte(kn));
        recent_key = kn;
    endtask

    task automatic send_tick();
        send_beat(MODE_TICK, 8'($urandom_range(0, 255)));
    endtask

    // hold off until every result beat is back and the block is quiet
    task automatic settle_idle();
        key_if.valid <= 1'b0;
        while (predicted_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [7:0] ticks);
        settle_idle();
        cfg_we <= 1'b1;
        cfg_data <= ticks;
        @(posedge clk);
        cfg_we <= 1'b0;
        timeout_limit = ticks;
    endtask

    // empty message corners, every key, wrap of key 0, star repeat
    task automatic test_directed_keys();
        send_tick();
        send_beat(MODE_PRESS, 8'hFF);
        send_beat(MODE_PRESS, 8'h00);
        send_beat(MODE_PRESS, KEY_BS);
        repeat (3) press_key(0);
        press_key(1);
        press_key(10);
        press_key(10);
        for (int k = 11; k >= 2; k--) press_key(k);
        send_beat(MODE_PRESS, KEY_BS);
        press_key(3);
        send_beat(MODE_PRESS, KEY_ENTER);
    endtask

    // timeout register at its extremes
    task automatic test_timeouts();
        write_timeout(8'd0);
        press_key(7);
        send_tick();
        repeat (10) press_key(9);
        send_tick();
        // idle count saturates, letter stays pending
        write_timeout(8'd255);
        press_key(5);
        repeat (258) send_tick();
        // saturated count is over a timeout of 254, next tick commits
        write_timeout(8'd254);
        send_tick();
        press_key(6);
        send_beat(MODE_PRESS, KEY_BS);
    endtask

    task automatic random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            if ($urandom_range(0, 1) == 1) press_key(recent_key);
            else press_key($urandom_range(0, 11));
        end else if (roll < 80) begin
            send_tick();
        end else if (roll < 86) begin
            send_beat(MODE_PRESS, KEY_BS);
        end else if (roll < 89) begin
            send_beat(MODE_PRESS, KEY_ENTER);
        end else begin
            send_beat(MODE_PRESS, 8'($urandom_range(0, 255)));
        end
    endtask

    // random traffic over several timeout settings
    task automatic test_random_traffic();
        logic [7:0] phase_timeout [6];
        phase_timeout = '{8'd1, 8'd0, 8'd3, 8'd2, 8'($urandom_range(0, 6)), 8'd8};
        for (int p = 0; p < 6; p++) begin
            write_timeout(phase_timeout[p]);
            no_idle = (p == 2);
            for (int i = 0; i < 8; i++) begin
                if (p == 3 && i == 4) settle_idle();
                random_item();
            end
            no_idle = 1'b0;
        end
    endtask

    // fill the message past capacity so commits get dropped
    task automatic test_full_message();
        int kn;
        send_beat(MODE_PRESS, KEY_ENTER);
        kn = $urandom_range(0, 11);
        for (int i = 0; i < 260; i++) begin
            no_idle = (i < 120);
            while (kn == recent_key) kn = $urandom_range(0, 11);
            press_key(kn);
            if ($urandom_range(0, 9) == 0) press_key(kn);
        end
        no_idle = 1'b0;
        send_beat(MODE_PRESS, KEY_BS);
        press_key(2);
        press_key(8);
        press_key(11);
        send_beat(MODE_PRESS, KEY_ENTER);
    endtask

    // main sequence
    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 8'd0;
        key_if.valid = 1'b0;
        key_if.mode = MODE_PRESS;
        key_if.key_code = 8'd0;
        res_if.ready = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        no_idle = 1'b0;
        recent_key = 0;
        timeout_limit = 8'(TIMEOUT_RESET);
        letter_pending = 1'b0;
        pending_key = 4'd0;
        pending_pos = 4'd0;
        idle_count = 8'd0;
        held_letters = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_keys();
        test_timeouts();
        test_random_traffic();
        test_full_message();

        settle_idle();
        if (mismatch_count == 0 && predicted_events.size() == 0) begin
            $display("multitap_keypad_text_entry_unit_test OK");
        end else begin
            $display("multitap_keypad_text_entry_unit_test NOT OK");
        end
        $finish;
    end

endmodule
